// File: hw/rtl/sme_pkg.sv
// Shared constants for the SPI master byte engine: register indexes, phase codes,
// register widths and reset values. No dependencies.
package sme_pkg;

    localparam int BITS_PER_WORD_DEF = 8;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP    = 2'd2;

    localparam logic [MODE_W-1:0] SPI_MODE_RST    = 2'd0;
    localparam logic [REG_W-1:0]  HALF_PERIOD_RST = 16'd50;
    localparam logic [REG_W-1:0]  BYTE_GAP_RST    = 16'd0;

    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FIRST  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PH_GAP    = 2'd3;

endpackage

// File: hw/rtl/sme_wait_ctr.sv
// Wait counter step for the SPI master byte engine: advances the tick count and
// flags the end of a wait. Depends on sme_pkg.
module sme_wait_ctr #(
    parameter int COUNT_WIDTH = sme_pkg::COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-1:0]   count,
    input  logic [sme_pkg::REG_W-1:0] target,
    output logic                     done,
    output logic [COUNT_WIDTH-1:0]   count_next
);
    import sme_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W) + 1;

    logic [CMP_W-1:0] count_inc;

    assign count_inc  = CMP_W'(count) + CMP_W'(1);
    assign done       = (count_inc >= CMP_W'(target)) || (&count);
    assign count_next = done ? '0 : count_inc[COUNT_WIDTH-1:0];

endmodule

// File: hw/rtl/spi_master_byte_engine.sv
// Top level of the SPI master byte engine: configuration registers, engine state
// and the result register. Depends on sme_pkg and sme_wait_ctr.
//
// Each input beat is one tick of the pin-level engine. It carries a start request
// with the byte to send and its last-of-buffer mark, plus the sampled MISO level.
// Each accepted input beat gives exactly one output beat with the SCK and MOSI
// levels after that tick, the busy flag and, on the tick a byte completes, the
// received byte with its last mark (rx_valid high).
// The configuration port writes spi_mode, half_period and byte_gap by index when
// cfg_we is high; the user must use it only while no transfer is running, which
// the block does not enforce. An input beat's output beat is presented in the
// next cycle from the result register. Throughput is one beat per cycle while the
// receiver takes beats, set by the combinational engine update between the state
// registers and the result register. When the receiver stalls, the result register
// holds its beat and in_ready drops until it is taken; the engine state advances
// only on accepted input beats. Reset clears the engine to idle with SCK low, MOSI
// low, registers at mode 0, half_period 50 and byte_gap 0, no output beat pending.
module spi_master_byte_engine #(
    parameter int BITS_PER_WORD = sme_pkg::BITS_PER_WORD_DEF,
    parameter int COUNT_WIDTH   = sme_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sme_pkg::REG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          start_req,
    input  logic [sme_pkg::BYTE_W-1:0]    tx_byte,
    input  logic                          last_byte,
    input  logic                          miso,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          sck,
    output logic                          mosi,
    output logic                          busy_res,
    output logic                          rx_valid,
    output logic [sme_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          rx_last
);
    import sme_pkg::*;

    localparam int BCW = $clog2(BITS_PER_WORD + 1);

    logic [MODE_W-1:0]        spi_mode_reg;
    logic [REG_W-1:0]         half_period_reg;
    logic [REG_W-1:0]         byte_gap_reg;

    logic                     sck_level_reg, sck_level_next;
    logic                     mosi_level_reg, mosi_level_next;
    logic [BITS_PER_WORD-1:0] tx_shift_reg, tx_shift_next;
    logic [BITS_PER_WORD-1:0] rx_shift_reg, rx_shift_next;
    logic [BCW-1:0]           bit_count_reg, bit_count_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   wait_count_reg, wait_count_next;
    logic                     last_flag_reg, last_flag_next;

    logic                     out_valid_reg;
    logic                     sck_reg, mosi_reg, busy_reg, rx_valid_reg, rx_last_reg;
    logic [BYTE_W-1:0]        rx_byte_reg;

    logic                     rx_valid_next, rx_last_next;
    logic [BYTE_W-1:0]        rx_byte_next;

    logic                     cpol, cpha;
    logic [REG_W-1:0]         hp_eff, wait_target;
    logic                     wait_done;
    logic [COUNT_WIDTH-1:0]   wait_step;
    logic [BITS_PER_WORD-1:0] tx_load;
    logic [BCW-1:0]           bit_inc;
    logic                     in_fire;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;

    assign cpol        = spi_mode_reg[1];
    assign cpha        = spi_mode_reg[0];
    assign hp_eff      = (half_period_reg == '0) ? REG_W'(1) : half_period_reg;
    assign wait_target = (phase_reg == PH_GAP) ? byte_gap_reg : hp_eff;
    assign tx_load     = BITS_PER_WORD'(tx_byte);
    assign bit_inc     = bit_count_reg + BCW'(1);

    sme_wait_ctr #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_wait_ctr (
        .count      (wait_count_reg),
        .target     (wait_target),
        .done       (wait_done),
        .count_next (wait_step)
    );

    always_comb
    begin
        sck_level_next  = sck_level_reg;
        mosi_level_next = mosi_level_reg;
        tx_shift_next   = tx_shift_reg;
        rx_shift_next   = rx_shift_reg;
        bit_count_next  = bit_count_reg;
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        last_flag_next  = last_flag_reg;
        rx_valid_next   = 1'b0;
        rx_byte_next    = '0;
        rx_last_next    = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                sck_level_next = cpol;
                if (start_req)
                begin
                    tx_shift_next   = tx_load;
                    last_flag_next  = last_byte;
                    rx_shift_next   = '0;
                    bit_count_next  = '0;
                    wait_count_next = '0;
                    mosi_level_next = tx_load[BITS_PER_WORD-1];
                    if (cpha)
                    begin
                        sck_level_next = ~cpol;
                    end
                    phase_next = PH_FIRST;
                end
            end
            PH_FIRST:
            begin
                wait_count_next = wait_step;
                if (wait_done)
                begin
                    rx_shift_next  = {rx_shift_reg[BITS_PER_WORD-2:0], miso};
                    sck_level_next = cpha ? cpol : ~cpol;
                    phase_next     = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                wait_count_next = wait_step;
                if (wait_done)
                begin
                    sck_level_next = cpol;
                    if (bit_inc < BCW'(BITS_PER_WORD))
                    begin
                        bit_count_next  = bit_inc;
                        tx_shift_next   = {tx_shift_reg[BITS_PER_WORD-2:0], 1'b0};
                        mosi_level_next = tx_shift_reg[BITS_PER_WORD-2];
                        if (cpha)
                        begin
                            sck_level_next = ~cpol;
                        end
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        rx_valid_next  = 1'b1;
                        rx_byte_next   = BYTE_W'(rx_shift_reg);
                        rx_last_next   = last_flag_reg;
                        bit_count_next = '0;
                        phase_next     = (byte_gap_reg != '0) ? PH_GAP : PH_IDLE;
                    end
                end
            end
            PH_GAP:
            begin
                sck_level_next  = cpol;
                wait_count_next = wait_step;
                if (wait_done)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_mode_reg    <= SPI_MODE_RST;
            half_period_reg <= HALF_PERIOD_RST;
            byte_gap_reg    <= BYTE_GAP_RST;
            sck_level_reg   <= SPI_MODE_RST[1];
            mosi_level_reg  <= 1'b0;
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            bit_count_reg   <= '0;
            phase_reg       <= PH_IDLE;
            wait_count_reg  <= '0;
            last_flag_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SPI_MODE)
                begin
                    spi_mode_reg <= cfg_data[MODE_W-1:0];
                end
                else if (cfg_index == CFG_HALF_PERIOD)
                begin
                    half_period_reg <= cfg_data;
                end
                else if (cfg_index == CFG_BYTE_GAP)
                begin
                    byte_gap_reg <= cfg_data;
                end
            end
            if (in_fire)
            begin
                sck_level_reg  <= sck_level_next;
                mosi_level_reg <= mosi_level_next;
                tx_shift_reg   <= tx_shift_next;
                rx_shift_reg   <= rx_shift_next;
                bit_count_reg  <= bit_count_next;
                phase_reg      <= phase_next;
                wait_count_reg <= wait_count_next;
                last_flag_reg  <= last_flag_next;
            end
            else if (cfg_we && cfg_index == CFG_SPI_MODE
                     && (phase_reg == PH_IDLE || phase_reg == PH_GAP))
            begin
                sck_level_reg <= cfg_data[1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sck_reg      <= sck_level_next;
            mosi_reg     <= mosi_level_next;
            busy_reg     <= (phase_next != PH_IDLE);
            rx_valid_reg <= rx_valid_next;
            rx_byte_reg  <= rx_byte_next;
            rx_last_reg  <= rx_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sck       = sck_reg;
    assign mosi      = mosi_reg;
    assign busy_res  = busy_reg;
    assign rx_valid  = rx_valid_reg;
    assign rx_byte   = rx_byte_reg;
    assign rx_last   = rx_last_reg;

    a_idle_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_count_reg == '0))
        else $error("bit count not cleared while idle");

    a_busy_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (busy_reg == (phase_reg != PH_IDLE)))
        else $error("busy flag disagrees with engine phase");

    a_idle_stays_without_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_IDLE && !start_req) |=> (phase_reg == PH_IDLE))
        else $error("engine left idle without a start request");

    a_idle_sck_polarity: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE || phase_reg == PH_GAP) |-> (sck_level_reg == spi_mode_reg[1]))
        else $error("SCK not at idle polarity outside a byte");

endmodule
